/* design/dbs_pkg.sv */
// shared types and constants of the deadband step servo
package dbs_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // register map
  localparam cfg_idx_t REG_DEADBAND      = 3'd0;
  localparam cfg_idx_t REG_STEP_SIZE     = 3'd1;
  localparam cfg_idx_t REG_SMOOTH_SHIFT  = 3'd2;
  localparam cfg_idx_t REG_DAC_CEILING   = 3'd3;
  localparam cfg_idx_t REG_STARTUP_LEVEL = 3'd4;

  // register field widths
  localparam int unsigned DEADBAND_W = 12;
  localparam int unsigned STEP_W     = 8;
  localparam int unsigned SHIFT_W    = 4;
  localparam int unsigned CEIL_W     = 8;
  localparam int unsigned STARTUP_W  = 8;

  // reset values
  localparam logic [DEADBAND_W-1:0] DEADBAND_RST = 12'd4;
  localparam logic [STEP_W-1:0]     STEP_RST     = 8'd1;
  localparam logic [SHIFT_W-1:0]    SHIFT_RST    = 4'd2;
  localparam logic [CEIL_W-1:0]     CEIL_RST     = 8'd255;
  localparam logic [STARTUP_W-1:0]  STARTUP_RST  = 8'd128;

endpackage

/* design/dbs_ema.sv */
// exponential moving average update with floor-rounded arithmetic shift
module dbs_ema #(
  parameter int unsigned WIDTH = 12
) (
  input  logic [WIDTH-1:0]            avg_i,
  input  logic [WIDTH-1:0]            sample_i,
  input  logic [dbs_pkg::SHIFT_W-1:0] shift_i,
  output logic [WIDTH-1:0]            next_o
);
  import dbs_pkg::*;

  logic signed [WIDTH:0] diff;
  logic signed [WIDTH:0] delta;
  logic signed [WIDTH:0] sum;

  always_comb begin
    diff  = $signed({1'b0, sample_i}) - $signed({1'b0, avg_i});
    // arithmetic shift rounds toward minus infinity
    delta = diff >>> shift_i;
    sum   = $signed({1'b0, avg_i}) + delta;
  end

  assign next_o = sum[WIDTH-1:0];

endmodule

/* design/deadband_step_servo.sv */
// top level of the deadband step servo with smoothed setpoint and feedback
// the result of an accepted feedback beat is registered in the output register
// throughput: one sample beat per cycle, one result per setpoint/feedback pair
// the sample channel stalls only while an untaken result sits in the output register
// reset (async, active low): config registers to their defaults, phase expects a setpoint,
// averages unprimed, dac level at the startup default; config port always ready
module deadband_step_servo #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned DAC_BITS    = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write channel
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  dbs_pkg::cfg_idx_t       cfg_index_i,
  input  dbs_pkg::cfg_data_t      cfg_data_i,
  // sample channel
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [SAMPLE_BITS-1:0]  sample_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [DAC_BITS-1:0]     dac_value_o,
  output logic [SAMPLE_BITS-1:0]  setpoint_filtered_o,
  output logic [SAMPLE_BITS-1:0]  feedback_filtered_o,
  output logic signed [SAMPLE_BITS:0] error_o
);
  import dbs_pkg::*;

  // width for the signed deadband compare, roomy enough for error and band
  localparam int unsigned EW = ((SAMPLE_BITS + 1 > DEADBAND_W) ? SAMPLE_BITS + 1
                                                               : DEADBAND_W) + 1;
  // width that holds both a dac level and an 8-bit register
  localparam int unsigned CW = (DAC_BITS > STEP_W) ? DAC_BITS : STEP_W;
  localparam logic [CW-1:0] DAC_MASK = CW'({DAC_BITS{1'b1}});

  // configuration registers
  logic [DEADBAND_W-1:0] deadband_q;
  logic [STEP_W-1:0]     step_q;
  logic [SHIFT_W-1:0]    shift_q;
  logic [CEIL_W-1:0]     ceil_q;

  // servo state
  logic                   phase_q;     // high: next beat is feedback
  logic                   primed_q;
  logic [SAMPLE_BITS-1:0] held_sp_q;
  logic [SAMPLE_BITS-1:0] sp_avg_q, sp_avg_d;
  logic [SAMPLE_BITS-1:0] fb_avg_q, fb_avg_d;
  logic [DAC_BITS-1:0]    level_q, level_d;

  // output register
  logic                       out_valid_q, out_valid_d;
  logic [DAC_BITS-1:0]        dac_q;
  logic [SAMPLE_BITS-1:0]     sp_out_q;
  logic [SAMPLE_BITS-1:0]     fb_out_q;
  logic signed [SAMPLE_BITS:0] err_q, err_d;

  logic                   in_acc;
  logic                   pair_done;
  logic                   cfg_acc;
  logic                   level_load;
  logic [SAMPLE_BITS-1:0] sp_ema, fb_ema;
  logic signed [EW-1:0]   err_ext, band_ext;
  logic                   go_up, go_down;
  logic [CW-1:0]          level_w, step_w, ceil_w, down_w;
  logic [CW:0]            up_w;

  // output register frees itself when its beat is taken, so a new sample
  // can come in the same cycle
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign pair_done   = in_acc && phase_q;
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  // a startup level write wins over a correction in the same cycle
  assign level_load  = cfg_acc && (cfg_index_i == REG_STARTUP_LEVEL);

  // running average updates, used once the first pair has loaded them
  dbs_ema #(.WIDTH(SAMPLE_BITS)) u_sp_ema (
    .avg_i    (sp_avg_q),
    .sample_i (held_sp_q),
    .shift_i  (shift_q),
    .next_o   (sp_ema)
  );

  dbs_ema #(.WIDTH(SAMPLE_BITS)) u_fb_ema (
    .avg_i    (fb_avg_q),
    .sample_i (sample_i),
    .shift_i  (shift_q),
    .next_o   (fb_ema)
  );

  always_comb begin
    // first pair primes the averages with the raw samples
    sp_avg_d = primed_q ? sp_ema : held_sp_q;
    fb_avg_d = primed_q ? fb_ema : sample_i;
    err_d    = $signed({1'b0, sp_avg_d}) - $signed({1'b0, fb_avg_d});

    // deadband test on sign-extended error
    err_ext  = {{(EW-SAMPLE_BITS-1){err_d[SAMPLE_BITS]}}, err_d};
    band_ext = $signed({{(EW-DEADBAND_W){1'b0}}, deadband_q});
    go_up    = err_ext > band_ext;
    go_down  = err_ext < -band_ext;

    // saturating step, limits cut to the dac width
    level_w = CW'(level_q);
    step_w  = CW'(step_q) & DAC_MASK;
    ceil_w  = CW'(ceil_q) & DAC_MASK;
    up_w    = {1'b0, level_w} + {1'b0, step_w};
    down_w  = (level_w >= step_w) ? (level_w - step_w) : '0;

    if (go_up) begin
      level_d = (up_w > {1'b0, ceil_w}) ? ceil_w[DAC_BITS-1:0] : up_w[DAC_BITS-1:0];
    end else if (go_down) begin
      level_d = down_w[DAC_BITS-1:0];
    end else begin
      level_d = level_q;
    end
  end

  always_comb begin
    if (pair_done) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // configuration and servo state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q  <= DEADBAND_RST;
      step_q      <= STEP_RST;
      shift_q     <= SHIFT_RST;
      ceil_q      <= CEIL_RST;
      phase_q     <= 1'b0;
      primed_q    <= 1'b0;
      held_sp_q   <= '0;
      sp_avg_q    <= '0;
      fb_avg_q    <= '0;
      level_q     <= DAC_BITS'(STARTUP_RST);
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        phase_q <= !phase_q;
        if (!phase_q) begin
          held_sp_q <= sample_i;
        end else begin
          primed_q <= 1'b1;
          sp_avg_q <= sp_avg_d;
          fb_avg_q <= fb_avg_d;
          if (!level_load) begin
            level_q <= level_d;
          end
        end
      end
      if (cfg_acc) begin
        case (cfg_index_i)
          REG_DEADBAND:     deadband_q <= cfg_data_i[DEADBAND_W-1:0];
          REG_STEP_SIZE:    step_q     <= cfg_data_i[STEP_W-1:0];
          REG_SMOOTH_SHIFT: shift_q    <= cfg_data_i[SHIFT_W-1:0];
          REG_DAC_CEILING:  ceil_q     <= cfg_data_i[CEIL_W-1:0];
          REG_STARTUP_LEVEL: begin
            // new startup level replaces the servo level at once; the dac output shows it with the next result
            level_q   <= DAC_BITS'(cfg_data_i[STARTUP_W-1:0]);
          end
          default: ;
        endcase
      end
    end
  end

  // result payload, loaded only when a pair completes
  always_ff @(posedge clk_i) begin
    if (pair_done) begin
      dac_q    <= level_d;
      sp_out_q <= sp_avg_d;
      fb_out_q <= fb_avg_d;
      err_q    <= err_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign dac_value_o         = dac_q;
  assign setpoint_filtered_o = sp_out_q;
  assign feedback_filtered_o = fb_out_q;
  assign error_o             = err_q;

endmodule

/* design/dbs_checker.sv */
// port-level checks of the deadband step servo, bound to the top level
module dbs_checker #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned DAC_BITS    = 8
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [DAC_BITS-1:0]         dac_value_o,
  input logic [SAMPLE_BITS-1:0]      setpoint_filtered_o,
  input logic [SAMPLE_BITS-1:0]      feedback_filtered_o,
  input logic signed [SAMPLE_BITS:0] error_o
);
  import dbs_pkg::*;

  logic in_acc;
  logic stalled;
  logic phase_q;

  assign in_acc  = in_valid_i && in_ready_o;
  assign stalled = out_valid_o && !out_ready_i;

  // mirror of the setpoint/feedback alternation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else if (in_acc) begin
      phase_q <= !phase_q;
    end
  end

  // a waiting result holds still
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stalled |=> out_valid_o && $stable(dac_value_o) && $stable(error_o))
    else $error("result changed while stalled");

  // a feedback beat gives a result in the next cycle
  a_pair_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && phase_q |=> out_valid_o)
    else $error("feedback beat gave no result");

  // a setpoint beat gives none
  a_sp_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !phase_q && !stalled |=> !out_valid_o)
    else $error("setpoint beat gave a result");

  // reported error matches the reported averages
  a_err_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> error_o == ($signed({1'b0, setpoint_filtered_o})
                               - $signed({1'b0, feedback_filtered_o})))
    else $error("error does not match averages");

endmodule

bind deadband_step_servo dbs_checker #(
  .SAMPLE_BITS(SAMPLE_BITS),
  .DAC_BITS   (DAC_BITS)
) u_dbs_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_ready_o          (in_ready_o),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .dac_value_o         (dac_value_o),
  .setpoint_filtered_o (setpoint_filtered_o),
  .feedback_filtered_o (feedback_filtered_o),
  .error_o             (error_o)
);

/* sim/deadband_step_servo_test.sv */
// self-checking testbench of the deadband step servo: directed rows, then random phases
`timescale 1ns / 1ps

module deadband_step_servo_test;
  import dbs_pkg::*;

  localparam int unsigned SW          = 12;
  localparam int unsigned DW          = 8;
  localparam int          SAMPLE_MAX  = (1 << SW) - 1;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          PHASES      = 9;
  localparam int          PHASE_BEATS = 60;

  // indexes the block does not decode, writes there must change nothing
  localparam cfg_idx_t REG_UNUSED_LO = 3'd5;
  localparam cfg_idx_t REG_UNUSED_HI = 3'd7;

  // one correction as it leaves the block
  typedef struct packed {
    logic [DW-1:0]      dac;
    logic [SW-1:0]      sp_avg;
    logic [SW-1:0]      fb_avg;
    logic signed [SW:0] err;
  } correction_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  // one line of the directed part; typed rows carry a hand-written result
  typedef struct {
    row_kind_e   kind;
    cfg_idx_t    idx;
    cfg_data_t   value;
    bit          typed;
    correction_t want;
  } stim_row_t;

  // block ports, all inputs known from time zero
  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  cfg_idx_t      cfg_index_i = '0;
  cfg_data_t     cfg_data_i  = '0;
  logic          in_valid_i  = 1'b0;
  logic          in_ready_o;
  logic [SW-1:0] sample_i    = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  logic [DW-1:0] dac_value_o;
  logic [SW-1:0] setpoint_filtered_o;
  logic [SW-1:0] feedback_filtered_o;
  logic signed [SW:0] error_o;

  // register copies
  logic [DEADBAND_W-1:0] band_q    = DEADBAND_RST;
  logic [STEP_W-1:0]     step_q    = STEP_RST;
  logic [SHIFT_W-1:0]    shift_q   = SHIFT_RST;
  logic [CEIL_W-1:0]     ceil_q    = CEIL_RST;

  // servo state copies
  bit            phase_q  = 1'b0;  // set while a setpoint is held
  logic [SW-1:0] held_q   = '0;
  logic [SW-1:0] sp_avg_q = '0;
  logic [SW-1:0] fb_avg_q = '0;
  bit            primed_q = 1'b0;
  logic [DW-1:0] level_q  = STARTUP_RST;

  correction_t due_results[$];   // corrections still owed by the block
  correction_t oldest;
  stim_row_t   directed_rows[$];

  int errors      = 0;
  int cycle_count = 0;
  int stall_left  = 0;
  bit feed_pauses  = 1'b1;  // sender idles in bursts
  bit drain_pauses = 1'b1;  // receiver stalls in bursts

  // per-phase shape of the random samples
  bit wide_mix = 1'b1;
  int sp_base  = 0;
  int fb_base  = 0;
  int spread   = 0;

  deadband_step_servo DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .sample_i            (sample_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .dac_value_o         (dac_value_o),
    .setpoint_filtered_o (setpoint_filtered_o),
    .feedback_filtered_o (feedback_filtered_o),
    .error_o             (error_o)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------- prediction

  // average moves by the difference shifted right, rounding toward minus infinity
  function automatic logic [SW-1:0] smooth(logic [SW-1:0] avg, logic [SW-1:0] s);
    int a;
    int diff;
    int nxt;
    a    = int'(avg);
    diff = int'(s) - a;
    nxt  = a + (diff >>> shift_q);
    return nxt[SW-1:0];
  endfunction

  // advance the servo by one sample; returns 1 when a correction comes out
  function automatic bit predict_correction(input logic [SW-1:0] s, output correction_t r);
    int err;
    int band;
    int lvl;
    int stp;
    int top;
    r = '0;
    if (!phase_q) begin
      held_q  = s;
      phase_q = 1'b1;
      return 1'b0;
    end
    phase_q = 1'b0;
    if (!primed_q) begin
      // first pair loads both averages straight
      sp_avg_q = held_q;
      fb_avg_q = s;
      primed_q = 1'b1;
    end else begin
      sp_avg_q = smooth(sp_avg_q, held_q);
      fb_avg_q = smooth(fb_avg_q, s);
    end
    err  = int'(sp_avg_q) - int'(fb_avg_q);
    band = int'(band_q);
    lvl  = int'(level_q);
    stp  = int'(step_q);
    top  = int'(ceil_q);
    if (err > band) begin
      // saturate at the ceiling, even when the level already sits above it
      lvl = (lvl + stp > top) ? top : lvl + stp;
    end else if (err < -band) begin
      lvl = (lvl >= stp) ? lvl - stp : 0;
    end
    level_q  = lvl[DW-1:0];
    r.dac    = level_q;
    r.sp_avg = sp_avg_q;
    r.fb_avg = fb_avg_q;
    r.err    = err[SW:0];
    return 1'b1;
  endfunction

  function automatic void apply_register(cfg_idx_t idx, cfg_data_t val);
    case (idx)
      REG_DEADBAND:      band_q  = val[DEADBAND_W-1:0];
      REG_STEP_SIZE:     step_q  = val[STEP_W-1:0];
      REG_SMOOTH_SHIFT:  shift_q = val[SHIFT_W-1:0];
      REG_DAC_CEILING:   ceil_q  = val[CEIL_W-1:0];
      REG_STARTUP_LEVEL: begin
        // level reloads at once, phase and averages stay
        level_q   = val[DW-1:0];
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- driving

  // one sample beat; valid held until taken, then the predictor runs
  task automatic push_sample(input logic [SW-1:0] s, input bit typed, input correction_t want);
    correction_t got;
    @(negedge clk_i);
    if (feed_pauses && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (predict_correction(s, got)) due_results.push_back(typed ? want : got);
  endtask

  // register beat, only once the servo has drained
  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    // a setpoint beat may still be settling inside
    repeat (2) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_register(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // extremes often, small values often, unused upper data bits random
  function automatic cfg_data_t pick_value(int unsigned w);
    int unsigned top;
    int unsigned v;
    top = (1 << w) - 1;
    case ($urandom_range(0, 4))
      0:       v = 0;
      1:       v = top;
      2:       v = $urandom_range(0, (top < 40) ? top : 40);
      default: v = $urandom_range(0, top);
    endcase
    v = v | ($urandom() & ~top);
    return v[CFG_DATA_W-1:0];
  endfunction

  function automatic logic [SW-1:0] draw_sample();
    int v;
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? SAMPLE_MAX[SW-1:0] : '0;
    if (wide_mix) return SW'($urandom_range(0, SAMPLE_MAX));
    v = (phase_q ? fb_base : sp_base) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return v[SW-1:0];
  endfunction

  // directed row builders
  function automatic stim_row_t w_row(cfg_idx_t idx, int val);
    stim_row_t r;
    r       = '{kind: ROW_WRITE, idx: idx, value: '0, typed: 1'b0, want: '0};
    r.value = val[CFG_DATA_W-1:0];
    return r;
  endfunction

  function automatic stim_row_t s_row(int s);
    stim_row_t r;
    r       = '{kind: ROW_SAMPLE, idx: '0, value: '0, typed: 1'b0, want: '0};
    r.value = s[CFG_DATA_W-1:0];
    return r;
  endfunction

  function automatic stim_row_t c_row(int s, int dac, int sp, int fb, int err);
    stim_row_t r;
    r             = s_row(s);
    r.typed       = 1'b1;
    r.want.dac    = dac[DW-1:0];
    r.want.sp_avg = sp[SW-1:0];
    r.want.fb_avg = fb[SW-1:0];
    r.want.err    = err[SW:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- receiving

  // result side ready: random stall bursts, none in the last phase
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (drain_pauses && $urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(0, 12);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic void compare_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  // every result beat against the oldest owed correction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none actual dac %0d error %0d",
                 $time, dac_value_o, error_o);
        errors++;
      end else begin
        oldest = due_results.pop_front();
        compare_field("dac_value", oldest.dac, dac_value_o);
        compare_field("setpoint_filtered", oldest.sp_avg, setpoint_filtered_o);
        compare_field("feedback_filtered", oldest.fb_avg, feedback_filtered_o);
        compare_field("error", $signed(oldest.err), $signed(error_o));
      end
    end
  end

  // hang guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    cfg_idx_t    reg_list[5];
    int unsigned reg_width[5];
    stim_row_t   row;

    reg_list  = '{REG_DEADBAND, REG_STEP_SIZE, REG_SMOOTH_SHIFT, REG_DAC_CEILING,
                  REG_STARTUP_LEVEL};
    reg_width = '{DEADBAND_W, STEP_W, SHIFT_W, CEIL_W, STARTUP_W};

    // defaults: band 4, step 1, shift 2, ceiling 255, level 128
    directed_rows.push_back(s_row(0));
    directed_rows.push_back(c_row(0, 128, 0, 0, 0));            // priming pair
    directed_rows.push_back(s_row(4095));
    directed_rows.push_back(c_row(0, 129, 1023, 0, 1023));      // quarter step toward 4095
    directed_rows.push_back(w_row(REG_SMOOTH_SHIFT, 0));        // averages follow samples
    directed_rows.push_back(s_row(4095));
    directed_rows.push_back(c_row(0, 130, 4095, 0, 4095));
    directed_rows.push_back(s_row(0));
    directed_rows.push_back(c_row(4095, 129, 0, 4095, -4095));
    directed_rows.push_back(w_row(REG_STEP_SIZE, 255));
    directed_rows.push_back(s_row(4095));
    directed_rows.push_back(c_row(0, 255, 4095, 0, 4095));      // step beyond headroom
    directed_rows.push_back(s_row(0));
    directed_rows.push_back(c_row(4095, 0, 0, 4095, -4095));
    directed_rows.push_back(s_row(0));
    directed_rows.push_back(c_row(4095, 0, 0, 4095, -4095));    // step larger than level
    directed_rows.push_back(w_row(REG_DAC_CEILING, 0));
    directed_rows.push_back(s_row(4095));
    directed_rows.push_back(c_row(0, 0, 4095, 0, 4095));        // zero ceiling
    directed_rows.push_back(w_row(REG_DAC_CEILING, 100));
    directed_rows.push_back(w_row(REG_STEP_SIZE, 0));
    directed_rows.push_back(s_row(4095));
    directed_rows.push_back(c_row(0, 0, 4095, 0, 4095));        // zero step holds
    directed_rows.push_back(w_row(REG_STEP_SIZE, 1));
    directed_rows.push_back(w_row(REG_STARTUP_LEVEL, 200));
    directed_rows.push_back(s_row(4095));
    directed_rows.push_back(c_row(0, 100, 4095, 0, 4095));      // level above ceiling
    directed_rows.push_back(w_row(REG_DEADBAND, 4095));
    directed_rows.push_back(s_row(4095));
    directed_rows.push_back(c_row(0, 100, 4095, 0, 4095));      // widest band holds
    directed_rows.push_back(s_row(0));
    directed_rows.push_back(c_row(4095, 100, 0, 4095, -4095));
    directed_rows.push_back(w_row(REG_UNUSED_LO, 4095));        // ignored writes
    directed_rows.push_back(w_row(REG_UNUSED_HI, 0));
    directed_rows.push_back(w_row(REG_DEADBAND, 0));
    directed_rows.push_back(w_row(REG_SMOOTH_SHIFT, 15));       // shift past the sample width
    directed_rows.push_back(s_row(2048));
    directed_rows.push_back(w_row(REG_STARTUP_LEVEL, 0));       // reload with a setpoint held
    directed_rows.push_back(s_row(2047));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) write_reg(row.idx, row.value);
      else push_sample(row.value[SW-1:0], row.typed, row.want);
    end

    // random phases, each with its own register setting and sample shape
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) begin
        feed_pauses  = 1'b0;
        drain_pauses = 1'b0;
      end
      foreach (reg_list[r]) begin
        if ($urandom_range(0, 1) == 1) write_reg(reg_list[r], pick_value(reg_width[r]));
      end
      if ($urandom_range(0, 3) == 0)
        write_reg(cfg_idx_t'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                  cfg_data_t'($urandom()));
      // mostly a settling loop: feedback near setpoint, so the band decides
      wide_mix = ($urandom_range(0, 3) == 0);
      sp_base  = $urandom_range(0, SAMPLE_MAX);
      fb_base  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, SAMPLE_MAX)
                                              : sp_base + int'($urandom_range(0, 80)) - 40;
      case ($urandom_range(0, 3))
        0:       spread = 0;
        1:       spread = 3;
        2:       spread = 40;
        default: spread = 600;
      endcase
      repeat (PHASE_BEATS) push_sample(draw_sample(), 1'b0, '0);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/dbs_pkg.sv
design/dbs_ema.sv
design/deadband_step_servo.sv
design/dbs_checker.sv
sim/deadband_step_servo_test.sv
